// ===== design/alvl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alvl_pkg: shared types and constants for the block level / impact detector
// Field widths, register codes, back-end state encoding and queue status.
// ----------------------------------------------------------------------------
package alvl_pkg;

  localparam int MAX_BLOCK_SAMPLES_DEF = 2048;
  localparam int QUEUE_DEPTH           = 2;

  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 15;
  localparam int CROSS_W    = 11;
  localparam int RMS_W      = 24;
  localparam int BASE_W     = 32;
  localparam int ABS_W      = 15;
  localparam int REL_W      = 8;
  localparam int ALPHA_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int RAD_W      = 2 * RMS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ABS_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_FACTOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q16     = 2'd2;

  localparam logic [ABS_W-1:0]   ABS_THRESHOLD_RST = 15'd3000;
  localparam logic [REL_W-1:0]   REL_FACTOR_RST    = 8'd8;
  localparam logic [ALPHA_W-1:0] ALPHA_Q16_RST     = 16'd328;
  localparam logic [BASE_W-1:0]  BASELINE_RST      = 32'd32768000;

  localparam logic [CROSS_W-1:0] CROSS_MAX = 11'h7FF;
  localparam logic [PEAK_W-1:0]  PEAK_MAX  = 15'h7FFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_REL,
    ST_MULA,
    ST_MULB,
    ST_FIN
  } alvl_state_t;

  typedef struct packed {
    logic full;
    logic nearly_full;
    logic empty;
  } alvl_qstat_t;

endpackage

// ===== design/alvl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alvl_front: per-sample accumulation
// Takes one sample per cycle when not stalled, tracks peak, crossings, count,
// squares magnitude in one stage, sums it in the next, pushes a block record.
// ----------------------------------------------------------------------------
module alvl_front import alvl_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEF,
  localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 2),
  localparam int SUM_W = CNT_W + 30
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  input  alvl_qstat_t                qstat,
  output logic                       push,
  output logic [SUM_W-1:0]           push_sum,
  output logic [CNT_W-1:0]           push_cnt,
  output logic [PEAK_W-1:0]          push_peak,
  output logic [CROSS_W-1:0]         push_cross
);

  logic                accept;
  logic                taken;
  logic [SAMPLE_W-1:0] sample_u;
  logic [SAMPLE_W-1:0] mag16;
  logic [PEAK_W-1:0]   mag15;
  logic                nonneg;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [PEAK_W-1:0]  peak_r, peak_nxt, peak_upd;
  logic [CROSS_W-1:0] cross_r, cross_nxt, cross_upd;
  logic               prev_r, prev_nxt;
  logic [SQ_W-1:0]    sq_r;
  logic               sq_v_r;
  logic               last_d_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt, sum_acc;
  logic [CNT_W-1:0]   rec_cnt_r;
  logic [PEAK_W-1:0]  rec_peak_r;
  logic [CROSS_W-1:0] rec_cross_r;

  assign in_stall = qstat.full || (qstat.nearly_full && last_d_r);
  assign accept   = in_valid && !in_stall;
  assign taken    = accept && ((cnt_r < CNT_W'(MAX_BLOCK_SAMPLES)) || in_last);

  assign sample_u = $unsigned(in_sample);
  assign mag16    = sample_u[SAMPLE_W-1] ? (~sample_u + 16'd1) : sample_u;
  assign mag15    = mag16[SAMPLE_W-1] ? PEAK_MAX : mag16[PEAK_W-1:0];
  assign nonneg   = !sample_u[SAMPLE_W-1];

  always_comb begin
    cnt_inc   = cnt_r + 1'b1;
    peak_upd  = (mag15 > peak_r) ? mag15 : peak_r;
    cross_upd = cross_r;
    if ((cnt_r != '0) && (nonneg != prev_r) && (cross_r != CROSS_MAX)) begin
      cross_upd = cross_r + 1'b1;
    end
    cnt_nxt   = cnt_r;
    peak_nxt  = peak_r;
    cross_nxt = cross_r;
    prev_nxt  = prev_r;
    if (taken) begin
      if (in_last) begin
        cnt_nxt   = '0;
        peak_nxt  = '0;
        cross_nxt = '0;
        prev_nxt  = 1'b0;
      end else begin
        cnt_nxt   = cnt_inc;
        peak_nxt  = peak_upd;
        cross_nxt = cross_upd;
        prev_nxt  = nonneg;
      end
    end
  end

  assign sum_acc = sq_v_r ? (sum_r + SUM_W'(sq_r)) : sum_r;

  always_comb begin
    sum_nxt = sum_acc;
    if (last_d_r) begin
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      peak_r   <= '0;
      cross_r  <= '0;
      prev_r   <= 1'b0;
      sq_v_r   <= 1'b0;
      last_d_r <= 1'b0;
      sum_r    <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      peak_r   <= peak_nxt;
      cross_r  <= cross_nxt;
      prev_r   <= prev_nxt;
      sq_v_r   <= taken;
      last_d_r <= accept && in_last;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (taken) begin
      sq_r <= mag16 * mag16;
    end
    if (accept && in_last) begin
      rec_cnt_r   <= cnt_inc;
      rec_peak_r  <= peak_upd;
      rec_cross_r <= cross_upd;
    end
  end

  assign push       = last_d_r;
  assign push_sum   = sum_acc;
  assign push_cnt   = rec_cnt_r;
  assign push_peak  = rec_peak_r;
  assign push_cross = rec_cross_r;

endmodule

// ===== design/alvl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alvl_queue: short record queue between front and back
// Power-of-two depth, head visible at the output, status as a struct.
// ----------------------------------------------------------------------------
module alvl_queue import alvl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LVL_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output alvl_qstat_t      qstat
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data           = mem_r[rd_ptr_r];
  assign qstat.full        = (level_r == LVL_W'(DEPTH));
  assign qstat.nearly_full = (level_r >= LVL_W'(DEPTH - 1));
  assign qstat.empty       = (level_r == '0);

endmodule

// ===== design/alvl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alvl_back: end-of-block arithmetic
// Radix-2 divide of the scaled sum by the count, bit-pair square root,
// impact test, two-step EMA multiply and the registered result.
// ----------------------------------------------------------------------------
module alvl_back import alvl_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEF,
  localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 2),
  localparam int SUM_W  = CNT_W + 30,
  localparam int DIV_W  = SUM_W + 16,
  localparam int STEP_W = $clog2(DIV_W + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  logic [SUM_W-1:0]    head_sum,
  input  logic [CNT_W-1:0]    head_cnt,
  input  logic [PEAK_W-1:0]   head_peak,
  input  logic [CROSS_W-1:0]  head_cross,
  output logic                pop,
  input  logic [ABS_W-1:0]    abs_threshold,
  input  logic [REL_W-1:0]    rel_factor,
  input  logic [ALPHA_W-1:0]  alpha_q16,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RMS_W-1:0]    out_rms_q8,
  output logic [PEAK_W-1:0]   out_peak,
  output logic [CROSS_W-1:0]  out_zero_crossings,
  output logic [BASE_W-1:0]   out_baseline_used,
  output logic                out_impact
);

  alvl_state_t st_r, st_nxt;

  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [DIV_W-1:0]   dq_r;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   div_r;
  logic [RMS_W-1:0]   root_r;
  logic [RMS_W+1:0]   srem_r;
  logic [PEAK_W-1:0]  peak_r;
  logic [CROSS_W-1:0] cross_r;
  logic               impact_r;
  logic [47:0]        prod_a_r;
  logic [48:0]        prod_b_r;
  logic [BASE_W-1:0]  baseline_r, baseline_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               out_free;
  logic               div_done;
  logic               sqrt_done;
  logic               load_out;

  logic [CNT_W:0]     rem_sh, rem_sub;
  logic               div_ge;
  logic [RMS_W+3:0]   sq_sh, sq_trial, sq_sub;
  logic               sq_ge;
  logic [39:0]        rel_prod;
  logic [39:0]        peak_sh;
  logic [16:0]        inv_alpha;
  logic [49:0]        upd;

  assign out_free  = !out_valid_r || !out_stall;
  assign div_done  = (step_r == STEP_W'(DIV_W - 1));
  assign sqrt_done = (step_r == STEP_W'(RMS_W - 1));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (head_valid) st_nxt = ST_DIV;
      ST_DIV:  if (div_done) st_nxt = ST_SQRT;
      ST_SQRT: if (sqrt_done) st_nxt = ST_REL;
      ST_REL:  st_nxt = ST_MULA;
      ST_MULA: st_nxt = ST_MULB;
      ST_MULB: st_nxt = ST_FIN;
      ST_FIN:  if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    step_nxt = '0;
    unique case (st_r)
      ST_IDLE: pop = head_valid;
      ST_DIV:  step_nxt = div_done ? '0 : step_r + 1'b1;
      ST_SQRT: step_nxt = sqrt_done ? '0 : step_r + 1'b1;
      ST_FIN:  load_out = out_free;
      default: step_nxt = '0;
    endcase
  end

  assign rem_sh  = {rem_r, dq_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign div_ge  = (rem_sh >= {1'b0, div_r});

  assign sq_sh    = {srem_r, dq_r[RAD_W-1 -: 2]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_sub   = sq_sh - sq_trial;
  assign sq_ge    = (sq_sh >= sq_trial);

  assign rel_prod  = rel_factor * baseline_r;
  assign peak_sh   = {9'd0, peak_r, 16'd0};
  assign inv_alpha = 17'h10000 - {1'b0, alpha_q16};
  assign upd       = 50'(prod_a_r) + 50'(prod_b_r) + 50'd32768;

  always_comb begin
    baseline_nxt = baseline_r;
    if (load_out && !impact_r) begin
      baseline_nxt = upd[47:16];
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      step_r      <= '0;
      baseline_r  <= BASELINE_RST;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      step_r      <= step_nxt;
      baseline_r  <= baseline_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        if (head_valid) begin
          dq_r    <= {head_sum, 16'd0};
          rem_r   <= '0;
          div_r   <= head_cnt;
          root_r  <= '0;
          srem_r  <= '0;
          peak_r  <= head_peak;
          cross_r <= head_cross;
        end
      end
      ST_DIV: begin
        rem_r <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dq_r  <= {dq_r[DIV_W-2:0], div_ge};
      end
      ST_SQRT: begin
        srem_r <= sq_ge ? sq_sub[RMS_W+1:0] : sq_sh[RMS_W+1:0];
        root_r <= {root_r[RMS_W-2:0], sq_ge};
        dq_r   <= {dq_r[DIV_W-3:0], 2'b00};
      end
      ST_REL: begin
        impact_r <= (peak_sh > rel_prod) && (peak_r > abs_threshold);
      end
      ST_MULA: begin
        prod_a_r <= alpha_q16 * {root_r, 8'd0};
      end
      ST_MULB: begin
        prod_b_r <= inv_alpha * baseline_r;
      end
      ST_FIN: begin
        if (out_free) begin
          out_rms_q8         <= root_r;
          out_peak           <= peak_r;
          out_zero_crossings <= cross_r;
          out_baseline_used  <= baseline_r;
          out_impact         <= impact_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/audio_block_level_impact.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_block_level_impact: block RMS, peak, crossings and impact flag
// Streams signed samples, emits one result per block with an EMA baseline.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in_     | in_valid / in_stall | in_sample, in_last
//  out_    | out_valid/out_stall | rms_q8, peak, zero_crossings,
//          |                     | baseline_used, impact
//  cfg_    | cfg_valid/cfg_ready | cfg_index, cfg_data (cfg_ready always 1)
//
//  Samples are taken one per cycle unless in_stall is high; the front squares
//  and sums in two stages. The back end works out each block's result with the
//  radix-2 divider and bit-pair square root, one bit or bit pair per cycle.
//  in_stall rises when the two-entry record queue is full, or holds one record
//  while another is being written.
//  Synchronous active-low reset restores control state, settings and baseline.
// ----------------------------------------------------------------------------
module audio_block_level_impact import alvl_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [RMS_W-1:0]           out_rms_q8,
  output logic [PEAK_W-1:0]          out_peak,
  output logic [CROSS_W-1:0]         out_zero_crossings,
  output logic [BASE_W-1:0]          out_baseline_used,
  output logic                       out_impact,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 2);
  localparam int SUM_W  = CNT_W + 30;
  localparam int FIFO_W = SUM_W + CNT_W + PEAK_W + CROSS_W;

  logic [ABS_W-1:0]   abs_threshold_r, abs_threshold_nxt;
  logic [REL_W-1:0]   rel_factor_r, rel_factor_nxt;
  logic [ALPHA_W-1:0] alpha_q16_r, alpha_q16_nxt;

  alvl_qstat_t        qstat;
  logic               push;
  logic               pop;
  logic [SUM_W-1:0]   push_sum, head_sum;
  logic [CNT_W-1:0]   push_cnt, head_cnt;
  logic [PEAK_W-1:0]  push_peak, head_peak;
  logic [CROSS_W-1:0] push_cross, head_cross;
  logic [FIFO_W-1:0]  wr_data, rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    abs_threshold_nxt = abs_threshold_r;
    rel_factor_nxt    = rel_factor_r;
    alpha_q16_nxt     = alpha_q16_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ABS_THRESHOLD: abs_threshold_nxt = cfg_data[ABS_W-1:0];
        CFG_REL_FACTOR:    rel_factor_nxt    = cfg_data[REL_W-1:0];
        CFG_ALPHA_Q16:     alpha_q16_nxt     = cfg_data[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_threshold_r <= ABS_THRESHOLD_RST;
      rel_factor_r    <= REL_FACTOR_RST;
      alpha_q16_r     <= ALPHA_Q16_RST;
    end else begin
      abs_threshold_r <= abs_threshold_nxt;
      rel_factor_r    <= rel_factor_nxt;
      alpha_q16_r     <= alpha_q16_nxt;
    end
  end

  alvl_front #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .in_last   (in_last),
    .qstat     (qstat),
    .push      (push),
    .push_sum  (push_sum),
    .push_cnt  (push_cnt),
    .push_peak (push_peak),
    .push_cross(push_cross)
  );

  assign wr_data = {push_sum, push_cnt, push_peak, push_cross};
  assign {head_sum, head_cnt, head_peak, head_cross} = rd_data;

  alvl_queue #(
    .WIDTH(FIFO_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(wr_data),
    .pop    (pop),
    .rd_data(rd_data),
    .qstat  (qstat)
  );

  alvl_back #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (!qstat.empty),
    .head_sum          (head_sum),
    .head_cnt          (head_cnt),
    .head_peak         (head_peak),
    .head_cross        (head_cross),
    .pop               (pop),
    .abs_threshold     (abs_threshold_r),
    .rel_factor        (rel_factor_r),
    .alpha_q16         (alpha_q16_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rms_q8        (out_rms_q8),
    .out_peak          (out_peak),
    .out_zero_crossings(out_zero_crossings),
    .out_baseline_used (out_baseline_used),
    .out_impact        (out_impact)
  );

endmodule
